[rtl/smwd_pkg.sv]
package smwd_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_DEL_MID = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  count;
    logic [31:0] top_value;
    logic [31:0] middle_value;
    logic [31:0] removed_value;
  } out_item_t;

  // Broadcast from the control logic to every cell of the row.
  typedef struct packed {
    logic                  push_en;
    logic                  del_en;
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      mid;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctl_t;

endpackage

[rtl/smwd_cell.sv]
module smwd_cell
  import smwd_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] upper_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] top_data,
  output logic [DATA_WIDTH-1:0] mid_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  is_top;
  logic                  is_mid;
  logic                  occupied;

  assign occupied = (ctl.count != '0);
  assign is_top   = occupied && ((CNT_W'(idx) + 1'b1) == ctl.count);
  assign is_mid   = occupied && (idx == ctl.mid);

  // A push writes the cell just above the current top; a middle delete pulls
  // the neighbor's word into every cell from the middle upward.
  always_comb begin
    data_nxt = data_r;
    if (ctl.push_en && (CNT_W'(idx) == ctl.count)) begin
      data_nxt = ctl.value;
    end else if (ctl.del_en && (idx >= ctl.mid)) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  assign top_data = is_top ? data_r : '0;
  assign mid_data = is_mid ? data_r : '0;

endmodule

[rtl/stack_with_middle_delete_core.sv]
// Bounded stack with a middle delete.
// Input channel: an item (op, value) is taken at a rising edge where start is
// high and busy is low. Op push stores value on top, pop removes the top entry
// and delete removes the entry at position floor((count-1)/2) from the bottom,
// moving every entry above it down one place. An unused op code reports the
// current view and changes nothing.
// Result channel: every item yields exactly one result, shown on out_item for
// one cycle while out_valid is high. The valid flag is registered in
// pend_valid_r and then in out_valid_r, and out_item is registered. The result
// carries the status, the new count, the top and middle entries
// and the removed entry. The receiver cannot stall, so no result is held back.
// Throughput is one item per cycle: each operation is a single parallel
// update of the cell row, and the next item sees the updated row.
// Reset clears the count and the output strobes and raises busy for the reset
// cycles; the cell contents are left as they are and are never read before
// they are written again. Pop or delete on an empty stack and push on a full
// one report an error status and change nothing.
module stack_with_middle_delete_core
  import smwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic accept;

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             pend_valid_r;
  logic [1:0]       pend_status_r;
  logic [31:0]      pend_removed_r;
  logic             out_valid_r;
  out_item_t        out_item_r;

  logic [1:0]       status_nxt;
  logic [31:0]      removed_nxt;
  logic             is_empty;
  logic             is_full;
  cell_ctl_t        ctl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_top  [DEPTH];
  logic [DATA_WIDTH-1:0] cell_mid  [DEPTH];
  logic [DATA_WIDTH-1:0] top_sel;
  logic [DATA_WIDTH-1:0] mid_sel;

  assign accept   = start && !busy_r;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r >= CNT_W'(DEPTH));

  // Decode the operation against the current fill level. The removed word is
  // read from the row before the update, which is the view left by the
  // previous item.
  always_comb begin
    status_nxt   = ST_DONE;
    removed_nxt  = '0;
    count_nxt    = count_r;
    ctl.push_en  = 1'b0;
    ctl.del_en   = 1'b0;
    ctl.count    = count_r;
    ctl.mid      = IDX_W'((count_r - 1'b1) >> 1);
    ctl.value    = DATA_WIDTH'(in_item.value);
    unique case (in_item.op)
      OP_PUSH: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.push_en = accept;
          count_nxt   = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          removed_nxt = 32'(top_sel);
          count_nxt   = count_r - 1'b1;
        end
      end
      OP_DEL_MID: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ctl.del_en  = accept;
          removed_nxt = 32'(mid_sel);
          count_nxt   = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The row of cells: entry zero is the bottom of the stack, and each cell above
  // the middle entry hands its word to the cell below it during a middle delete.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic [DATA_WIDTH-1:0] upper;
    if (gi == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_inner
      assign upper = cell_data[gi + 1];
    end
    smwd_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(gi)),
      .ctl        (ctl),
      .upper_data (upper),
      .data       (cell_data[gi]),
      .top_data   (cell_top[gi]),
      .mid_data   (cell_mid[gi])
    );
  end

  // At most one cell flags itself as top and one as middle, so an OR over
  // the masked words picks them out; both are zero on an empty stack.
  always_comb begin
    top_sel = '0;
    mid_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      top_sel = top_sel | cell_top[i];
      mid_sel = mid_sel | cell_mid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= 1'b0;
      pend_valid_r <= accept;
      out_valid_r  <= pend_valid_r;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers. The second stage samples the row in the cycle after the
  // update, when it holds the view after the operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status_r  <= status_nxt;
      pend_removed_r <= removed_nxt;
    end
    out_item_r.status        <= pend_status_r;
    out_item_r.count         <= 7'(count_r);
    out_item_r.top_value     <= 32'(top_sel);
    out_item_r.middle_value  <= 32'(mid_sel);
    out_item_r.removed_value <= pend_removed_r;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.op == OP_PUSH) && !is_full |=>
      count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("push did not grow the stack");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_empty && ((in_item.op == OP_POP) || (in_item.op == OP_DEL_MID))
      |=> is_empty && (pend_status_r == ST_EMPTY))
    else $error("operation on empty stack changed state");

  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_item_r.count == 7'd0) |->
      (out_item_r.top_value == '0) && (out_item_r.middle_value == '0))
    else $error("empty stack reported a nonzero view");
`endif

endmodule
